/* sv/kdfp_pkg.sv */
// Shared types and constants for the keyed decimal field parser.
package kdfp_pkg;

  localparam int unsigned ValueW = 31;
  localparam int unsigned FracW  = 3;
  localparam int unsigned PowW   = 14;

  localparam logic [ValueW-1:0] ValueMax = {ValueW{1'b1}};

  localparam logic [1:0] ModeInt   = 2'd0;
  localparam logic [1:0] ModeFrac3 = 2'd1;
  localparam logic [1:0] ModeFrac4 = 2'd2;

  localparam logic [7:0] CharZero = 8'd48;
  localparam logic [7:0] CharDigitLo = 8'd47;
  localparam logic [7:0] CharDigitHi = 8'd58;
  localparam logic [7:0] CharDot  = 8'h2E;

  typedef struct packed {
    logic [ValueW-1:0] value;
    logic [FracW-1:0]  pad;
    logic              ovf;
    logic              not_found;
  } kdfp_emit_t;

  function automatic logic [FracW-1:0] frac_digits(input logic [1:0] mode);
    logic [FracW-1:0] r;
    case (mode)
      ModeFrac3: r = FracW'(3);
      ModeFrac4: r = FracW'(4);
      default:   r = FracW'(0);
    endcase
    return r;
  endfunction

  function automatic logic [PowW-1:0] pow10(input logic [FracW-1:0] k);
    logic [PowW-1:0] r;
    case (k)
      FracW'(1): r = PowW'(10);
      FracW'(2): r = PowW'(100);
      FracW'(3): r = PowW'(1000);
      FracW'(4): r = PowW'(10000);
      default:   r = PowW'(1);
    endcase
    return r;
  endfunction

endpackage

/* sv/kdfp_scan.sv */
// Per-byte scan and digit accumulation with the parse state registers.
module kdfp_scan
  import kdfp_pkg::*;
#(
  parameter int unsigned SCAN_LIMIT = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [7:0]       char_in_i,
  input  logic [7:0]       key_letter_i,
  input  logic             line_start_i,
  input  logic             line_end_i,
  input  logic [1:0]       mode_i,
  output logic             emit_o,
  output kdfp_emit_t       emit_data_o
);

  localparam int unsigned CntW = (SCAN_LIMIT > 1) ? $clog2(SCAN_LIMIT) : 1;

  localparam logic [1:0] PhSearch = 2'd0;
  localparam logic [1:0] PhRead   = 2'd1;
  localparam logic [1:0] PhDone   = 2'd2;

  logic [1:0]        phase_q, phase_d, phase_c;
  logic [ValueW-1:0] acc_q, acc_d, acc_c;
  logic [FracW-1:0]  frac_q, frac_d, frac_c;
  logic              dot_q, dot_d, dot_c;
  logic [CntW-1:0]   cnt_q, cnt_d, cnt_c;
  logic              ovf_q, ovf_d, ovf_c;

  logic [FracW-1:0]  want;
  logic              is_digit;
  logic [3:0]        digit;
  logic [ValueW+3:0] pushed;
  logic              push_ovf;
  logic [CntW:0]     cnt_inc;

  always_comb begin
    phase_c = line_start_i ? PhSearch : phase_q;
    acc_c   = line_start_i ? '0 : acc_q;
    frac_c  = line_start_i ? '0 : frac_q;
    dot_c   = line_start_i ? 1'b0 : dot_q;
    cnt_c   = line_start_i ? '0 : cnt_q;
    ovf_c   = line_start_i ? 1'b0 : ovf_q;
  end

  assign want     = frac_digits(mode_i);
  assign is_digit = (char_in_i > CharDigitLo) && (char_in_i < CharDigitHi);
  assign digit    = 4'(char_in_i - CharZero);
  assign pushed   = {3'b000, acc_c, 1'b0} + {1'b0, acc_c, 3'b000}
                  + (ValueW+4)'(digit);
  assign push_ovf = pushed > (ValueW+4)'(ValueMax);
  assign cnt_inc  = {1'b0, cnt_c} + (CntW+1)'(1);

  always_comb begin
    phase_d = phase_c;
    acc_d   = acc_c;
    frac_d  = frac_c;
    dot_d   = dot_c;
    cnt_d   = cnt_c;
    ovf_d   = ovf_c;
    emit_o  = 1'b0;
    emit_data_o = '0;
    unique case (phase_c)
      PhSearch: begin
        if (char_in_i == key_letter_i) begin
          phase_d = PhRead;
          if (line_end_i) begin
            emit_o = 1'b1;
            emit_data_o.pad = want;
            phase_d = PhDone;
          end
        end else if (32'(cnt_inc) >= SCAN_LIMIT || line_end_i) begin
          emit_o = 1'b1;
          emit_data_o.not_found = 1'b1;
          phase_d = PhDone;
        end else begin
          cnt_d = cnt_inc[CntW-1:0];
        end
      end
      PhRead: begin
        if (is_digit) begin
          if (!dot_c || frac_c < want) begin
            acc_d = push_ovf ? ValueMax : pushed[ValueW-1:0];
            ovf_d = ovf_c | push_ovf;
            if (dot_c) begin
              frac_d = frac_c + FracW'(1);
            end
          end
        end else if (char_in_i == CharDot && !dot_c && want != '0) begin
          dot_d = 1'b1;
        end else begin
          emit_o = 1'b1;
        end
        if (line_end_i) begin
          emit_o = 1'b1;
        end
        if (emit_o) begin
          emit_data_o.value = acc_d;
          emit_data_o.ovf   = ovf_d;
          emit_data_o.pad   = (want > frac_d) ? want - frac_d : '0;
          phase_d = PhDone;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhSearch;
      acc_q   <= '0;
      frac_q  <= '0;
      dot_q   <= 1'b0;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      frac_q  <= frac_d;
      dot_q   <= dot_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
    end
  end

endmodule

/* sv/kdfp_scale.sv */
// Fraction padding stage with saturation and the result register.
module kdfp_scale
  import kdfp_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  kdfp_emit_t        emit_data_i,
  output logic              ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ValueW-1:0] number_value_o,
  output logic              not_found_o,
  output logic              saturated_o
);

  logic       pad_vq, pad_vd;
  kdfp_emit_t pad_q;
  logic       out_vq, out_vd;
  logic [ValueW-1:0] val_q;
  logic       nf_q, sat_q;

  logic                   out_free;
  logic                   pad_adv;
  logic [ValueW+PowW-1:0] prod;
  logic                   prod_ovf;

  assign out_free = !out_vq || out_ready_i;
  assign pad_adv  = pad_vq && out_free;
  assign ready_o  = !pad_vq || out_free;

  assign prod     = (ValueW+PowW)'(pad_q.value) * (ValueW+PowW)'(pow10(pad_q.pad));
  assign prod_ovf = prod[ValueW+PowW-1:ValueW] != '0;

  always_comb begin
    pad_vd = pad_vq;
    if (load_i) begin
      pad_vd = 1'b1;
    end else if (out_free) begin
      pad_vd = 1'b0;
    end
    out_vd = out_free ? pad_vq : out_vq;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pad_vq <= 1'b0;
      out_vq <= 1'b0;
    end else begin
      pad_vq <= pad_vd;
      out_vq <= out_vd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pad_q <= emit_data_i;
    end
    if (pad_adv) begin
      val_q <= prod_ovf ? ValueMax : prod[ValueW-1:0];
      nf_q  <= pad_q.not_found;
      sat_q <= pad_q.ovf | prod_ovf;
    end
  end

  assign out_valid_o    = out_vq;
  assign number_value_o = val_q;
  assign not_found_o    = nf_q;
  assign saturated_o    = sat_q;

endmodule

/* sv/keyed_decimal_field_parser_unit.sv */
// Top level: keyed decimal field parser, one command-line byte per request.
// Result path: the field's last byte loads the padding register, then the result register.
// Throughput: one byte per cycle while in_ready_o is high; the byte scan updates its state on each byte,
// and the fraction-padding multiply sits in its own stage before the result register.
// Reset: parser starts in key search with cleared state, number mode plain integer.
module keyed_decimal_field_parser_unit
  import kdfp_pkg::*;
#(
  parameter int unsigned SCAN_LIMIT = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [1:0]        cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        char_in_i,
  input  logic [7:0]        key_letter_i,
  input  logic              line_start_i,
  input  logic              line_end_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [ValueW-1:0] number_value_o,
  output logic              not_found_o,
  output logic              saturated_o
);

  logic [1:0] mode_q;
  logic       accept;
  logic       emit;
  kdfp_emit_t emit_data;

  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeInt;
    end else if (cfg_valid_i) begin
      mode_q <= cfg_data_i;
    end
  end

  kdfp_scan #(
    .SCAN_LIMIT(SCAN_LIMIT)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .char_in_i   (char_in_i),
    .key_letter_i(key_letter_i),
    .line_start_i(line_start_i),
    .line_end_i  (line_end_i),
    .mode_i      (mode_q),
    .emit_o      (emit),
    .emit_data_o (emit_data)
  );

  kdfp_scale u_scale (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (accept && emit),
    .emit_data_i   (emit_data),
    .ready_o       (in_ready_o),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .number_value_o(number_value_o),
    .not_found_o   (not_found_o),
    .saturated_o   (saturated_o)
  );

endmodule
